>>> hdl/vfu_pkg.sv
// ----------------------------------------------------------------------------
// vfu_pkg
// Shared widths, operation codes, sideband record and saturation helper for
// the Q16.16 three-component vector unit.
// ----------------------------------------------------------------------------
package vfu_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = 2 * WORD_W;          // one exact product
  localparam int ACC_W        = PROD_W + 2;          // sum of three products
  localparam int MAG_W        = ACC_W - FRAC_W;      // rounded magnitude
  localparam int FRONT_STAGES = 4;
  localparam int SQ_STAGES    = WORD_W;              // one root bit per stage
  localparam int SQ_REM_W     = WORD_W + 4;
  localparam int DIV_STAGES   = WORD_W + FRAC_W;     // one quotient bit per stage
  localparam int QUO_W        = DIV_STAGES;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DIV   = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_MAGSQ = 4'd7,
    OP_MAG   = 4'd8,
    OP_NORM  = 4'd9
  } op_t;

  typedef struct packed {
    logic  flt;
    word_t val;
  } res_t;

  // Travels alongside each transaction down the pipe.
  typedef struct packed {
    op_t   op;
    word_t vx;
    word_t vy;
    word_t vz;
    word_t sc;
    logic  flt;
    word_t ax;
    word_t ay;
    word_t az;
    word_t s;
  } side_t;

  // Sign and magnitude to a saturated word.
  function automatic res_t fin(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] limit;
    logic [MAG_W-1:0] m;
    res_t r;
    limit = neg ? (MAG_W'(1) << (WORD_W - 1))
                : ((MAG_W'(1) << (WORD_W - 1)) - MAG_W'(1));
    m     = mag;
    r.flt = 1'b0;
    if (mag > limit) begin
      m     = limit;
      r.flt = 1'b1;
    end
    r.val = neg ? -m[WORD_W-1:0] : m[WORD_W-1:0];
    return r;
  endfunction

endpackage

>>> hdl/vfu_front.sv
// ----------------------------------------------------------------------------
// vfu_front
// Four stages: operand select and multiply, product sums, rounding add,
// saturation and result select for scale, cross, dot and squared magnitude.
// ----------------------------------------------------------------------------
module vfu_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [3:0]                   req_type,
  input  vfu_pkg::word_t               ax,
  input  vfu_pkg::word_t               ay,
  input  vfu_pkg::word_t               az,
  input  vfu_pkg::word_t               bx,
  input  vfu_pkg::word_t               by,
  input  vfu_pkg::word_t               bz,
  input  vfu_pkg::word_t               scalar_in,
  output logic                         out_valid,
  output vfu_pkg::side_t               out_side,
  output logic [vfu_pkg::PROD_W-1:0]   out_rad
);

  localparam logic [vfu_pkg::ACC_W-1:0] HALF =
    vfu_pkg::ACC_W'(1) << (vfu_pkg::FRAC_W - 1);

  vfu_pkg::op_t   op_in;
  vfu_pkg::word_t ma [6];
  vfu_pkg::word_t mb [6];
  vfu_pkg::word_t a3 [3];
  vfu_pkg::word_t b3 [3];
  vfu_pkg::side_t sd1_next;

  logic                                v1, v2, v3;
  vfu_pkg::side_t                      sd1, sd2, sd3;
  logic signed [vfu_pkg::PROD_W-1:0]   p1 [6];
  logic signed [vfu_pkg::ACC_W-1:0]    l2_next [3];
  logic signed [vfu_pkg::ACC_W-1:0]    l2 [3];
  logic [vfu_pkg::PROD_W-1:0]          rad2, rad3;
  logic                                n3_next [3];
  logic [vfu_pkg::ACC_W-1:0]           m3_next [3];
  logic                                n3 [3];
  logic [vfu_pkg::ACC_W-1:0]           m3 [3];
  vfu_pkg::res_t                       rr [3];
  vfu_pkg::side_t                      sd4_next;

  // stage 1: operand select, multiply, add/sub/negate
  always_comb begin
    logic signed [vfu_pkg::WORD_W:0] s33;
    vfu_pkg::res_t                   sr [3];
    op_in = vfu_pkg::op_t'(req_type);
    a3[0] = ax; a3[1] = ay; a3[2] = az;
    b3[0] = bx; b3[1] = by; b3[2] = bz;
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (op_in) inside
      vfu_pkg::OP_SCALE: begin
        ma[0] = ax; mb[0] = scalar_in;
        ma[1] = ay; mb[1] = scalar_in;
        ma[2] = az; mb[2] = scalar_in;
      end
      vfu_pkg::OP_DOT: begin
        ma[0] = ax; mb[0] = bx;
        ma[1] = ay; mb[1] = by;
        ma[2] = az; mb[2] = bz;
      end
      vfu_pkg::OP_CROSS: begin
        ma[0] = ay; mb[0] = bz;  ma[3] = az; mb[3] = by;
        ma[1] = az; mb[1] = bx;  ma[4] = ax; mb[4] = bz;
        ma[2] = ax; mb[2] = by;  ma[5] = ay; mb[5] = bx;
      end
      vfu_pkg::OP_MAGSQ, vfu_pkg::OP_MAG, vfu_pkg::OP_NORM: begin
        ma[0] = ax; mb[0] = ax;
        ma[1] = ay; mb[1] = ay;
        ma[2] = az; mb[2] = az;
      end
      default: ;
    endcase

    for (int i = 0; i < 3; i++) begin
      case (op_in)
        vfu_pkg::OP_ADD: s33 = {a3[i][vfu_pkg::WORD_W-1], a3[i]}
                             + {b3[i][vfu_pkg::WORD_W-1], b3[i]};
        vfu_pkg::OP_SUB: s33 = {a3[i][vfu_pkg::WORD_W-1], a3[i]}
                             - {b3[i][vfu_pkg::WORD_W-1], b3[i]};
        default:         s33 = '0 - {a3[i][vfu_pkg::WORD_W-1], a3[i]};
      endcase
      sr[i].flt = s33[vfu_pkg::WORD_W] != s33[vfu_pkg::WORD_W-1];
      if (sr[i].flt)
        sr[i].val = s33[vfu_pkg::WORD_W] ? {1'b1, {(vfu_pkg::WORD_W-1){1'b0}}}
                                         : {1'b0, {(vfu_pkg::WORD_W-1){1'b1}}};
      else
        sr[i].val = s33[vfu_pkg::WORD_W-1:0];
    end

    sd1_next    = '0;
    sd1_next.op = op_in;
    sd1_next.ax = ax;
    sd1_next.ay = ay;
    sd1_next.az = az;
    sd1_next.s  = scalar_in;
    case (op_in) inside
      vfu_pkg::OP_ADD, vfu_pkg::OP_SUB, vfu_pkg::OP_NEG: begin
        sd1_next.vx  = sr[0].val;
        sd1_next.vy  = sr[1].val;
        sd1_next.vz  = sr[2].val;
        sd1_next.flt = sr[0].flt | sr[1].flt | sr[2].flt;
      end
      vfu_pkg::OP_SCALE, vfu_pkg::OP_DIV, vfu_pkg::OP_DOT, vfu_pkg::OP_CROSS,
      vfu_pkg::OP_MAGSQ, vfu_pkg::OP_MAG, vfu_pkg::OP_NORM: ;
      default: sd1_next.flt = 1'b1;   // unused code
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    sd1 <= sd1_next;
    for (int i = 0; i < 6; i++)
      p1[i] <= vfu_pkg::PROD_W'(ma[i]) * vfu_pkg::PROD_W'(mb[i]);
  end

  // stage 2: sums and differences of products
  always_comb begin
    logic signed [vfu_pkg::ACC_W-1:0] x [6];
    for (int i = 0; i < 6; i++)
      x[i] = vfu_pkg::ACC_W'(p1[i]);
    case (sd1.op) inside
      vfu_pkg::OP_DOT, vfu_pkg::OP_MAGSQ, vfu_pkg::OP_MAG, vfu_pkg::OP_NORM:
        l2_next[0] = x[0] + x[1] + x[2];
      default:
        l2_next[0] = x[0] - x[3];
    endcase
    l2_next[1] = x[1] - x[4];
    l2_next[2] = x[2] - x[5];
  end

  always_ff @(posedge clk) begin
    sd2  <= sd1;
    l2   <= l2_next;
    rad2 <= l2_next[0][vfu_pkg::PROD_W-1:0];
  end

  // stage 3: magnitude plus half an output lsb
  always_comb begin
    logic [vfu_pkg::ACC_W-1:0] lv;
    for (int i = 0; i < 3; i++) begin
      lv         = l2[i];
      n3_next[i] = lv[vfu_pkg::ACC_W-1];
      m3_next[i] = n3_next[i] ? (~lv + HALF + vfu_pkg::ACC_W'(1)) : (lv + HALF);
    end
  end

  always_ff @(posedge clk) begin
    sd3  <= sd2;
    rad3 <= rad2;
    n3   <= n3_next;
    m3   <= m3_next;
  end

  // stage 4: drop fraction, saturate, pick results
  always_comb begin
    for (int i = 0; i < 3; i++)
      rr[i] = vfu_pkg::fin(n3[i], m3[i][vfu_pkg::ACC_W-1:vfu_pkg::FRAC_W]);
    sd4_next = sd3;
    case (sd3.op) inside
      vfu_pkg::OP_SCALE, vfu_pkg::OP_CROSS: begin
        sd4_next.vx  = rr[0].val;
        sd4_next.vy  = rr[1].val;
        sd4_next.vz  = rr[2].val;
        sd4_next.flt = rr[0].flt | rr[1].flt | rr[2].flt;
      end
      vfu_pkg::OP_DOT, vfu_pkg::OP_MAGSQ: begin
        sd4_next.sc  = rr[0].val;
        sd4_next.flt = rr[0].flt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_side <= sd4_next;
    out_rad  <= rad3;
  end

endmodule

>>> hdl/vfu_sqrt.sv
// ----------------------------------------------------------------------------
// vfu_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives the floor root and the remainder.
// ----------------------------------------------------------------------------
module vfu_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [vfu_pkg::PROD_W-1:0]     rad,
  output logic                           out_valid,
  output logic [vfu_pkg::WORD_W-1:0]     root,
  output logic [vfu_pkg::SQ_REM_W-1:0]   rem
);

  localparam int N  = vfu_pkg::SQ_STAGES;
  localparam int RW = vfu_pkg::SQ_REM_W;

  logic                         vld    [N];
  logic [vfu_pkg::PROD_W-1:0]   rad_q  [N];
  logic [RW-1:0]                rem_q  [N];
  logic [vfu_pkg::WORD_W-1:0]   root_q [N];
  logic [vfu_pkg::PROD_W-1:0]   rad_n  [N];
  logic [RW-1:0]                rem_n  [N];
  logic [vfu_pkg::WORD_W-1:0]   root_n [N];

  always_comb begin
    logic [vfu_pkg::PROD_W-1:0] s_rad;
    logic [RW-1:0]              s_rem;
    logic [vfu_pkg::WORD_W-1:0] s_root;
    logic [RW-1:0]              r4;
    logic [RW-1:0]              trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        s_rad  = rad;
        s_rem  = '0;
        s_root = '0;
      end else begin
        s_rad  = rad_q[k-1];
        s_rem  = rem_q[k-1];
        s_root = root_q[k-1];
      end
      r4    = {s_rem[RW-3:0], s_rad[vfu_pkg::PROD_W-1 -: 2]};
      trial = RW'({s_root, 2'b01});
      if (r4 >= trial) begin
        rem_n[k]  = r4 - trial;
        root_n[k] = {s_root[vfu_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem_n[k]  = r4;
        root_n[k] = {s_root[vfu_pkg::WORD_W-2:0], 1'b0};
      end
      rad_n[k] = {s_rad[vfu_pkg::PROD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++)
        vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k < N; k++)
        vld[k] <= vld[k-1];
    end
    rad_q  <= rad_n;
    rem_q  <= rem_n;
    root_q <= root_n;
  end

  assign out_valid = vld[N-1];
  assign root      = root_q[N-1];
  assign rem       = rem_q[N-1];

`ifndef SYNTHESIS
  // floor root: remainder never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rem <= RW'({root, 1'b0}))
    else $error("sqrt remainder out of range");
`endif

endmodule

>>> hdl/vfu_div.sv
// ----------------------------------------------------------------------------
// vfu_div
// Pipelined restoring divider, one quotient bit per stage. Divides a word
// magnitude scaled by the fraction width by an unsigned word.
// ----------------------------------------------------------------------------
module vfu_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [vfu_pkg::WORD_W-1:0]   num,
  input  logic [vfu_pkg::WORD_W-1:0]   den,
  output logic                         out_valid,
  output logic [vfu_pkg::QUO_W-1:0]    quo,
  output logic [vfu_pkg::WORD_W-1:0]   rem,
  output logic [vfu_pkg::WORD_W-1:0]   den_out
);

  localparam int N  = vfu_pkg::DIV_STAGES;
  localparam int QW = vfu_pkg::QUO_W;
  localparam int W  = vfu_pkg::WORD_W;

  logic           vld [N];
  logic [QW-1:0]  n_q [N];
  logic [QW-1:0]  q_q [N];
  logic [W-1:0]   r_q [N];
  logic [W-1:0]   d_q [N];
  logic [QW-1:0]  n_n [N];
  logic [QW-1:0]  q_n [N];
  logic [W-1:0]   r_n [N];
  logic [W-1:0]   d_n [N];

  always_comb begin
    logic [QW-1:0] s_n;
    logic [QW-1:0] s_q;
    logic [W-1:0]  s_r;
    logic [W-1:0]  s_d;
    logic [W:0]    r2;
    logic          qb;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        s_n = {num, {vfu_pkg::FRAC_W{1'b0}}};
        s_q = '0;
        s_r = '0;
        s_d = den;
      end else begin
        s_n = n_q[k-1];
        s_q = q_q[k-1];
        s_r = r_q[k-1];
        s_d = d_q[k-1];
      end
      r2 = {s_r, s_n[QW-1]};
      qb = r2 >= {1'b0, s_d};
      if (qb)
        r_n[k] = W'(r2 - {1'b0, s_d});
      else
        r_n[k] = r2[W-1:0];
      q_n[k] = {s_q[QW-2:0], qb};
      n_n[k] = {s_n[QW-2:0], 1'b0};
      d_n[k] = s_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++)
        vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k < N; k++)
        vld[k] <= vld[k-1];
    end
    n_q <= n_n;
    q_q <= q_n;
    r_q <= r_n;
    d_q <= d_n;
  end

  assign out_valid = vld[N-1];
  assign quo       = q_q[N-1];
  assign rem       = r_q[N-1];
  assign den_out   = d_q[N-1];

`ifndef SYNTHESIS
  a_rem_lt_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rem < den_out)
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> hdl/vector3_fixed_point_unit_core.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_unit_core
// Q16.16 three-component vector ALU: add, sub, negate, scale, divide, dot,
// cross, squared magnitude, magnitude and normalize, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   | handshake        | payload
//  ----------+------------------+--------------------------------------------
//  request   | start / busy     | req_type, ax ay az, bx by bz, scalar_in
//  result    | done (strobe)    | rx ry rz, scalar_out, fault
//
//  A transaction is taken on each edge with start high and busy low; one can
//  be taken every cycle. Every transaction passes in turn through its stages:
//  4 front stages, 32 square-root stages, 1 divisor stage, 48 divider stages
//  and the output register. All operations run the full length so results
//  leave in order. done is high for exactly one cycle per result; the
//  receiver cannot stall and nothing inside ever stalls. busy is high only
//  during synchronous reset and the cycle after it.
//
module vector3_fixed_point_unit_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [3:0]      req_type,
  input  vfu_pkg::word_t  ax,
  input  vfu_pkg::word_t  ay,
  input  vfu_pkg::word_t  az,
  input  vfu_pkg::word_t  bx,
  input  vfu_pkg::word_t  by,
  input  vfu_pkg::word_t  bz,
  input  vfu_pkg::word_t  scalar_in,
  output logic            done,
  output vfu_pkg::word_t  rx,
  output vfu_pkg::word_t  ry,
  output vfu_pkg::word_t  rz,
  output vfu_pkg::word_t  scalar_out,
  output logic            fault
);

  localparam int W   = vfu_pkg::WORD_W;
  localparam int LAT = vfu_pkg::FRONT_STAGES + vfu_pkg::SQ_STAGES
                     + vfu_pkg::DIV_STAGES + 2;

  logic                             accept;
  logic                             f_valid;
  vfu_pkg::side_t                   f_side;
  logic [vfu_pkg::PROD_W-1:0]       f_rad;

  logic                             sq_valid;
  logic [W-1:0]                     sq_root;
  logic [vfu_pkg::SQ_REM_W-1:0]     sq_rem;
  vfu_pkg::side_t                   sq_line [vfu_pkg::SQ_STAGES];

  vfu_pkg::side_t                   mid_side_next;
  logic [W-1:0]                     mid_den_next;
  logic [W-1:0]                     mid_num_next [3];
  logic                             mid_valid;
  vfu_pkg::side_t                   mid_side;
  logic [W-1:0]                     mid_den;
  logic [W-1:0]                     mid_num [3];

  logic                             dv_valid;
  logic [vfu_pkg::QUO_W-1:0]        dv_quo [3];
  logic [W-1:0]                     dv_rem [3];
  logic [W-1:0]                     dv_den [3];
  vfu_pkg::side_t                   dv_line [vfu_pkg::DIV_STAGES];

  vfu_pkg::side_t                   out_next;

  // Nothing inside can stall; busy only covers reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start & ~busy;

  vfu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .req_type  (req_type),
    .ax        (ax),
    .ay        (ay),
    .az        (az),
    .bx        (bx),
    .by        (by),
    .bz        (bz),
    .scalar_in (scalar_in),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_rad   (f_rad)
  );

  vfu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .rad       (f_rad),
    .out_valid (sq_valid),
    .root      (sq_root),
    .rem       (sq_rem)
  );

  // sideband kept level with the root stages
  always_ff @(posedge clk) begin
    sq_line[0] <= f_side;
    for (int k = 1; k < vfu_pkg::SQ_STAGES; k++)
      sq_line[k] <= sq_line[k-1];
  end

  // Divisor stage: round the root, finish magnitude, choose the divisor.
  // A zero divisor raises fault here and the divider runs on a dummy one.
  always_comb begin
    vfu_pkg::side_t sd;
    logic [W:0]     m33;
    vfu_pkg::res_t  mres;
    logic [W-1:0]   smag;
    sd   = sq_line[vfu_pkg::SQ_STAGES-1];
    m33  = {1'b0, sq_root}
         + ((sq_rem > vfu_pkg::SQ_REM_W'(sq_root)) ? (W+1)'(1) : (W+1)'(0));
    mres = vfu_pkg::fin(1'b0, vfu_pkg::MAG_W'(m33));
    smag = sd.s[W-1] ? (~sd.s + 1'b1) : sd.s;
    mid_side_next = sd;
    mid_den_next  = W'(1);
    case (sd.op)
      vfu_pkg::OP_DIV: begin
        if (sd.s == '0)
          mid_side_next.flt = 1'b1;
        else
          mid_den_next = smag;
      end
      vfu_pkg::OP_NORM: begin
        if (m33 == '0)
          mid_side_next.flt = 1'b1;
        else
          mid_den_next = m33[W-1:0];
      end
      vfu_pkg::OP_MAG: begin
        mid_side_next.sc  = mres.val;
        mid_side_next.flt = mres.flt;
      end
      default: ;
    endcase
    mid_num_next[0] = sd.ax[W-1] ? (~sd.ax + 1'b1) : sd.ax;
    mid_num_next[1] = sd.ay[W-1] ? (~sd.ay + 1'b1) : sd.ay;
    mid_num_next[2] = sd.az[W-1] ? (~sd.az + 1'b1) : sd.az;
  end

  always_ff @(posedge clk) begin
    if (rst)
      mid_valid <= 1'b0;
    else
      mid_valid <= sq_valid;
    mid_side <= mid_side_next;
    mid_den  <= mid_den_next;
    mid_num  <= mid_num_next;
  end

  vfu_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .num       (mid_num[0]),
    .den       (mid_den),
    .out_valid (dv_valid),
    .quo       (dv_quo[0]),
    .rem       (dv_rem[0]),
    .den_out   (dv_den[0])
  );

  vfu_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .num       (mid_num[1]),
    .den       (mid_den),
    .out_valid (),
    .quo       (dv_quo[1]),
    .rem       (dv_rem[1]),
    .den_out   (dv_den[1])
  );

  vfu_div u_div_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .num       (mid_num[2]),
    .den       (mid_den),
    .out_valid (),
    .quo       (dv_quo[2]),
    .rem       (dv_rem[2]),
    .den_out   (dv_den[2])
  );

  always_ff @(posedge clk) begin
    dv_line[0] <= mid_side;
    for (int k = 1; k < vfu_pkg::DIV_STAGES; k++)
      dv_line[k] <= dv_line[k-1];
  end

  // Quotient rounding (half away from zero) and saturation.
  always_comb begin
    vfu_pkg::side_t            sd;
    logic [vfu_pkg::QUO_W:0]   rnd;
    logic                      neg;
    logic                      sneg;
    vfu_pkg::res_t             qr [3];
    sd   = dv_line[vfu_pkg::DIV_STAGES-1];
    sneg = (sd.op == vfu_pkg::OP_DIV) & sd.s[W-1];
    for (int i = 0; i < 3; i++) begin
      rnd = {1'b0, dv_quo[i]}
          + (({dv_rem[i], 1'b0} >= {1'b0, dv_den[i]}) ? (vfu_pkg::QUO_W+1)'(1)
                                                      : (vfu_pkg::QUO_W+1)'(0));
      case (i)
        0:       neg = sd.ax[W-1];
        1:       neg = sd.ay[W-1];
        default: neg = sd.az[W-1];
      endcase
      qr[i] = vfu_pkg::fin(neg ^ sneg, vfu_pkg::MAG_W'(rnd));
    end
    out_next = sd;
    case (sd.op) inside
      vfu_pkg::OP_DIV, vfu_pkg::OP_NORM: begin
        if (!sd.flt) begin
          out_next.vx  = qr[0].val;
          out_next.vy  = qr[1].val;
          out_next.vz  = qr[2].val;
          out_next.flt = qr[0].flt | qr[1].flt | qr[2].flt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      done <= 1'b0;
    else
      done <= dv_valid;
    rx         <= out_next.vx;
    ry         <= out_next.vy;
    rz         <= out_next.vz;
    scalar_out <= out_next.sc;
    fault      <= out_next.flt;
  end

`ifndef SYNTHESIS
  // every result strobe traces back to a request taken a fixed time before
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without matching request");

  // the dividers never see a zero divisor
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    mid_valid |-> mid_den != '0)
    else $error("zero divisor reached the divider");
`endif

endmodule
